/* hdl/pcf_pkg.sv */
// Package for the pitch complementary filter: payload structs, CORDIC table, sizes.
// No dependencies.
`default_nettype none
package pcf_pkg;
    localparam int CordicSteps = 16;
    localparam int StepW       = 5;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [9:0]         gyro_sample;
        logic               restart;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pitch;
        logic               ready_res;
        logic               accel_valid;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQX, ST_SQZ, ST_ROOT, ST_CORD, ST_DIV, ST_GMUL,
        ST_GINC, ST_BMUL, ST_BADD, ST_OUT
    } t_state;

    localparam logic [1:0] REG_WEIGHT = 2'd0;
    localparam logic [1:0] REG_SCALE  = 2'd1;
    localparam logic [1:0] REG_AVG    = 2'd2;

    // Rounded atan(2^-i) in Q16.16 degrees
    function automatic logic [21:0] atan_tab(input logic [StepW-1:0] i);
        logic [21:0] r;
        begin
            case (i)
                5'd0: r = 22'd2949120;  5'd1: r = 22'd1740967;
                5'd2: r = 22'd919879;   5'd3: r = 22'd466945;
                5'd4: r = 22'd234379;   5'd5: r = 22'd117304;
                5'd6: r = 22'd58666;    5'd7: r = 22'd29335;
                5'd8: r = 22'd14668;    5'd9: r = 22'd7334;
                5'd10: r = 22'd3667;    5'd11: r = 22'd1833;
                5'd12: r = 22'd917;     5'd13: r = 22'd458;
                5'd14: r = 22'd229;     5'd15: r = 22'd115;
                5'd16: r = 22'd57;      5'd17: r = 22'd29;
                5'd18: r = 22'd14;      5'd19: r = 22'd7;
                5'd20: r = 22'd4;       5'd21: r = 22'd2;
                5'd22: r = 22'd1;       default: r = 22'd0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

/* hdl/pcf_serial_mul.sv */
// Bit-serial shift-and-add multiplier: signed 36-bit multiplicand, unsigned 24-bit multiplier.
// Depends on pcf_pkg.
`default_nettype none
module pcf_serial_mul
    import pcf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [35:0] i_a,
    input  wire logic [23:0]        i_b,
    output logic                    o_done,
    output logic signed [63:0]      o_p
);
    logic [4:0]         r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic signed [63:0] r_acc, n_acc;
    logic signed [63:0] r_a, n_a;
    logic [23:0]        r_b, n_b;

    // Add one shifted multiplicand per multiplier bit
    always_comb begin
        n_cnt = r_cnt; n_busy = r_busy; n_acc = r_acc; n_a = r_a; n_b = r_b;
        o_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1; n_cnt = 5'd0; n_acc = '0;
            n_a = 64'(i_a); n_b = i_b;
        end else if (r_busy) begin
            if (r_b[0]) n_acc = r_acc + r_a;
            n_a = r_a <<< 1;
            n_b = r_b >> 1;
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd23) begin
                n_busy = 1'b0;
                o_done = 1'b1;
            end
        end
    end

    assign o_p = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_cnt <= n_cnt;
        end
        r_acc <= n_acc; r_a <= n_a; r_b <= n_b;
    end
endmodule
`default_nettype wire

/* hdl/pitch_complementary_filter_core.sv */
// Top level of the pitch complementary filter: APB registers, sequencer, serial datapath.
// Depends on pcf_pkg and pcf_serial_mul.
//
// Usage: one input item per sensor tick on i_in_* (valid/ready); one result item on
// o_out_* per input item. Registers are to be written over the APB port while no item is
// in work; the core does not enforce this. One item is in work at a time; o_in_ready is
// high only while the sequencer is idle. An initialising tick updates the gyro sum and
// runs a 26-step bias division. A filtering tick runs two serial squares, a 24-step
// square root, a 16-step CORDIC, a serial gyro product and the pitch update; when the
// accelerometer pitch is defined, two serial blend products follow. The products use
// the shift-and-add multiplier and the root works on bit pairs of the radicand.
// The result waits in an output register and the next item may be taken meanwhile;
// a stalled receiver holds the sequencer in its output state once the next result
// is ready. Reset clears the filter state and loads the register defaults.
`default_nettype none
module pitch_complementary_filter_core
    import pcf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    // Configuration registers
    logic [15:0] r_weight;
    logic [23:0] r_scale;
    logic [15:0] r_avg;
    logic [1:0]  w_idx;
    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= 16'd328; r_scale <= 24'd117029; r_avg <= 16'd200;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_WEIGHT: r_weight <= pwdata[15:0];
                REG_SCALE:  r_scale  <= pwdata[23:0];
                REG_AVG:    r_avg    <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WEIGHT: prdata = {16'd0, r_weight};
            REG_SCALE:  prdata = {8'd0, r_scale};
            REG_AVG:    prdata = {16'd0, r_avg};
            default:    prdata = '0;
        endcase
    end

    // Filter state and working registers
    t_state             r_st, n_st;
    logic [4:0]         r_k, n_k;
    logic signed [31:0] r_pitch;
    logic               r_init;
    logic [15:0]        r_cnt;
    logic [25:0]        r_sum;
    logic [9:0]         r_bias;
    t_in_item           r_in;
    logic               r_valid;
    logic [31:0]        r_sq;
    logic [47:0]        r_rad;   // radicand, shifted out two bits per step
    logic [24:0]        r_rem;
    logic [23:0]        r_root;
    logic signed [27:0] r_cx, r_cy;
    logic signed [31:0] r_z;
    logic [25:0]        r_q;
    logic [15:0]        r_dr;
    logic signed [63:0] r_mix;
    t_out_item          r_out;
    logic               r_ov;

    // Serial multiplier shared by squares, gyro and blend
    logic               m_start, m_done;
    logic signed [35:0] m_a;
    logic [23:0]        m_b;
    logic signed [63:0] m_p;

    pcf_serial_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(m_start),
        .i_a(m_a), .i_b(m_b), .o_done(m_done), .o_p(m_p)
    );

    logic signed [16:0] ax_abs, az_abs;
    assign ax_abs = r_in.accel_x[15] ? -17'(r_in.accel_x) : 17'(r_in.accel_x);
    assign az_abs = r_in.accel_z[15] ? -17'(r_in.accel_z) : 17'(r_in.accel_z);

    logic signed [16:0] num;
    assign num = -17'(r_in.accel_y);

    logic signed [10:0] rate;
    assign rate = signed'({1'b0, r_in.gyro_sample}) - signed'({1'b0, r_bias});

    // Initialising tick: count and sum, cleared first on restart
    logic [15:0] cnt_base;
    logic [25:0] sum_base;
    logic [25:0] sum_nx;
    assign cnt_base = i_in_data.restart ? 16'd0 : r_cnt;
    assign sum_base = i_in_data.restart ? 26'd0 : r_sum;
    assign sum_nx   = sum_base + 26'(i_in_data.gyro_sample);

    // Root step: one bit pair of the radicand per cycle
    logic [26:0] rem_sh;
    logic [26:0] trial;
    logic        root_bit;
    logic [23:0] root_nx;
    logic [24:0] rem_nx;
    assign rem_sh   = {r_rem, r_rad[47:46]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign root_bit = rem_sh >= trial;
    assign root_nx  = {r_root[22:0], root_bit};
    assign rem_nx   = root_bit ? 25'(rem_sh - trial) : rem_sh[24:0];

    // CORDIC step terms
    logic signed [27:0] cx_sh, cy_sh;
    logic signed [31:0] atan_step;
    assign cx_sh     = r_cx >>> r_k;
    assign cy_sh     = r_cy >>> r_k;
    assign atan_step = signed'(32'(atan_tab(r_k)));

    // Divider step: one quotient bit per cycle
    logic [16:0] dv_sh;
    logic        dv_bit;
    assign dv_sh  = {r_dr, r_q[25]};
    assign dv_bit = dv_sh >= {1'b0, r_cnt};

    // Gyro increment with rounding and the 180-degree limit
    logic signed [63:0] inc;
    logic signed [63:0] psum;
    logic               inc_ok;
    assign inc    = (r_mix + 64'sd128) >>> 8;
    assign inc_ok = (inc <= 64'sd11796480) && (inc >= -64'sd11796480);
    assign psum   = 64'(r_pitch) + inc;

    logic signed [63:0] blend;
    assign blend = (r_mix + m_p + 64'sd32768) >>> 16;

    function automatic logic signed [31:0] sat(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        end
    endfunction

    logic out_load;
    assign out_load    = (r_st == ST_OUT) && (!r_ov || i_out_ready);
    assign o_in_ready  = (r_st == ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // Sequencer: next state, step count and multiplier start
    always_comb begin
        n_st = r_st; n_k = r_k; m_start = 1'b0; m_a = '0; m_b = '0;
        unique case (r_st)
            ST_IDLE: if (i_in_valid) begin
                n_st = (!r_init || i_in_data.restart) ? ST_DIV : ST_SQX;
                n_k  = '0;
            end
            ST_SQX: if (r_k == 5'd0) begin
                m_start = 1'b1; m_a = 36'(ax_abs); m_b = 24'(ax_abs); n_k = 5'd1;
            end else if (m_done) begin
                n_st = ST_SQZ; n_k = '0;
            end
            ST_SQZ: if (r_k == 5'd0) begin
                m_start = 1'b1; m_a = 36'(az_abs); m_b = 24'(az_abs); n_k = 5'd1;
            end else if (m_done) begin
                n_st = ST_ROOT; n_k = '0;
            end
            ST_ROOT: if (r_k == 5'd23) begin
                n_st = ST_CORD; n_k = '0;
            end else begin
                n_k = r_k + 5'd1;
            end
            ST_CORD: if (r_k == 5'(CordicSteps - 1)) begin
                n_st = ST_GMUL; n_k = '0;
            end else begin
                n_k = r_k + 5'd1;
            end
            ST_DIV: if (r_k == 5'd26) begin
                n_st = ST_OUT; n_k = '0;
            end else begin
                n_k = r_k + 5'd1;
            end
            ST_GMUL: if (r_k == 5'd0) begin
                m_start = 1'b1; m_a = 36'(rate); m_b = r_scale; n_k = 5'd1;
            end else if (m_done) begin
                n_st = ST_GINC; n_k = '0;
            end
            ST_GINC: begin
                n_st = r_valid ? ST_BMUL : ST_OUT; n_k = '0;
            end
            ST_BMUL: if (r_k == 5'd0) begin
                m_start = 1'b1; m_a = 36'(r_z); m_b = 24'(r_weight); n_k = 5'd1;
            end else if (m_done) begin
                n_st = ST_BADD; n_k = '0;
            end
            ST_BADD: if (r_k == 5'd0) begin
                m_start = 1'b1; m_a = 36'(r_pitch);
                m_b = 24'(17'h10000 - 17'(r_weight)); n_k = 5'd1;
            end else if (m_done) begin
                n_st = ST_OUT; n_k = '0;
            end
            ST_OUT: if (!r_ov || i_out_ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_k <= '0;
        end else begin
            r_st <= n_st; r_k <= n_k;
        end
    end

    // Filter state: init bookkeeping, bias and pitch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= '0; r_init <= 1'b0; r_cnt <= '0; r_sum <= '0; r_bias <= '0;
        end else begin
            case (r_st)
                ST_IDLE: if (i_in_valid) begin
                    if (i_in_data.restart) begin
                        r_init <= 1'b0; r_bias <= '0;
                    end
                    if (!r_init || i_in_data.restart) begin
                        r_cnt   <= (cnt_base != 16'hffff) ? cnt_base + 16'd1 : cnt_base;
                        r_sum   <= sum_nx;
                        r_pitch <= '0;
                    end
                end
                ST_DIV: if (r_k == 5'd26 && r_cnt >= r_avg) begin
                    r_bias <= r_q[9:0]; r_init <= 1'b1;
                end
                ST_GINC: if (inc_ok) r_pitch <= sat(psum);
                ST_BADD: if (m_done) r_pitch <= sat(blend);
                default: ;
            endcase
        end
    end

    // Working datapath: squares, root, CORDIC, division, products
    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: if (i_in_valid) begin
                r_in <= i_in_data; r_valid <= 1'b0;
                r_q <= sum_nx; r_dr <= '0;
            end
            ST_SQX: if (m_done) r_sq <= m_p[31:0];
            ST_SQZ: if (m_done) begin
                r_rad <= {r_sq + m_p[31:0], 16'd0};
                r_rem <= '0; r_root <= '0;
            end
            ST_ROOT: begin
                r_rad  <= {r_rad[45:0], 2'b00};
                r_rem  <= rem_nx;
                r_root <= root_nx;
                if (r_k == 5'd23) begin
                    // Load the vector for CORDIC and flag a defined angle
                    r_cx    <= 28'(root_nx);
                    r_cy    <= 28'(num) <<< 8;
                    r_z     <= '0;
                    r_valid <= (num != 17'sd0) || (root_nx != 24'd0);
                end
            end
            ST_CORD: if (r_cy >= 28'sd0) begin
                r_cx <= r_cx + cy_sh;
                r_cy <= r_cy - cx_sh;
                r_z  <= r_z + atan_step;
            end else begin
                r_cx <= r_cx - cy_sh;
                r_cy <= r_cy + cx_sh;
                r_z  <= r_z - atan_step;
            end
            ST_DIV: if (r_k != 5'd26) begin
                r_dr <= dv_bit ? 16'(dv_sh - {1'b0, r_cnt}) : dv_sh[15:0];
                r_q  <= {r_q[24:0], dv_bit};
            end
            ST_GMUL: if (m_done) r_mix <= m_p;
            ST_BMUL: if (m_done) r_mix <= m_p;
            default: ;
        endcase
    end

    // Output register: load when free or being taken, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.pitch       <= r_pitch;
            r_out.ready_res   <= r_init;
            r_out.accel_valid <= r_valid;
        end
    end
endmodule
`default_nettype wire
